// ===== design/mcbb_pkg.sv =====
`default_nettype none
package mcbb_pkg;

    localparam int ROW_W           = 64;
    localparam int IDX_W           = 6;
    localparam int CNT_W           = 7;
    localparam int PRUNE_W         = 32;
    localparam int MAX_VERTICES_DEF = 64;

    // main sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_SYM,
        S_RK_HEAD,
        S_RK_SWEEP,
        S_RA_HEAD1,
        S_RA_HEAD2,
        S_RA_SWEEP,
        S_ROOT,
        S_LOOP,
        S_BR_WAIT,
        S_COLOR,
        S_POP,
        S_POP_WAIT,
        S_MASK,
        S_OUT
    } t_state;

    // coloring unit
    typedef enum logic [1:0] {
        C_IDLE,
        C_PICK,
        C_WAIT
    } t_col_state;

    typedef struct packed {
        logic [IDX_W-1:0] addr;
    } t_col_req;

    typedef struct packed {
        logic done;
        logic prune;
    } t_col_stat;

    // population count, pairwise field adds
    function automatic logic [CNT_W-1:0] f_popcount(input logic [ROW_W-1:0] x);
        logic [ROW_W-1:0] s;
        s = x;
        s = (s & 64'h5555_5555_5555_5555) + ((s >> 1) & 64'h5555_5555_5555_5555);
        s = (s & 64'h3333_3333_3333_3333) + ((s >> 2) & 64'h3333_3333_3333_3333);
        s = (s & 64'h0F0F_0F0F_0F0F_0F0F) + ((s >> 4) & 64'h0F0F_0F0F_0F0F_0F0F);
        s = (s & 64'h00FF_00FF_00FF_00FF) + ((s >> 8) & 64'h00FF_00FF_00FF_00FF);
        s = (s & 64'h0000_FFFF_0000_FFFF) + ((s >> 16) & 64'h0000_FFFF_0000_FFFF);
        s = (s & 64'h0000_0000_FFFF_FFFF) + ((s >> 32) & 64'h0000_0000_FFFF_FFFF);
        return s[CNT_W-1:0];
    endfunction

    // lowest set bit as one-hot
    function automatic logic [ROW_W-1:0] f_low_onehot(input logic [ROW_W-1:0] x);
        return x & (~x + 64'd1);
    endfunction

    // highest set bit as one-hot
    function automatic logic [ROW_W-1:0] f_high_onehot(input logic [ROW_W-1:0] x);
        logic [ROW_W-1:0] s;
        s = x;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        s = s | (s >> 32);
        return s & ~(s >> 1);
    endfunction

    // one-hot to index
    function automatic logic [IDX_W-1:0] f_encode(input logic [ROW_W-1:0] oh);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int j = 0; j < ROW_W; j++) begin
            if (oh[j]) begin
                idx = idx | IDX_W'(j);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== design/max_clique_branch_bound.sv =====
`default_nettype none
// Maximum clique search by branch and bound with a greedy coloring bound.
// Input channel (i_in_valid/o_in_ready): a request with i_kind 0 writes the
// adjacency row i_row_index (one per cycle while idle, no result); i_kind 1
// starts a solve over the first vertex_count vertices and yields one result.
// Configuration channel (i_cfg_valid/o_cfg_ready), always ready, writes
// vertex_count; it is written only while the block is idle (not enforced).
// Output channel (o_out_valid/i_out_ready): clique size, member mask and
// saturating prune count. A waiting result holds; loads are still taken,
// a new solve waits until the result is taken.
// A solve with n vertices first prepares: symmetrize, rank by degree, build
// ranked adjacency, each a sweep of the row memories with one read per cycle.
// Then the search: branches and the coloring bound go through the single
// read port of the ranked adjacency memory, and pops read the candidate
// stack memory. Finally the mask is mapped back to vertex numbers.
// Data dependent overall.
// Reset clears the control state and vertex_count; adjacency rows are
// undefined until loaded.
module max_clique_branch_bound #(
    parameter int MAX_VERTICES = mcbb_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_kind,
    input  wire logic [mcbb_pkg::IDX_W-1:0]         i_row_index,
    input  wire logic [mcbb_pkg::ROW_W-1:0]         i_row_bits,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [mcbb_pkg::CNT_W-1:0]              o_clique_size,
    output logic [mcbb_pkg::ROW_W-1:0]              o_clique_mask,
    output logic [mcbb_pkg::PRUNE_W-1:0]            o_prune_count,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mcbb_pkg::CNT_W-1:0]         i_cfg_data
);

    localparam int IW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int RW  = mcbb_pkg::ROW_W;
    localparam int CW  = mcbb_pkg::CNT_W;
    localparam int XW  = mcbb_pkg::IDX_W;
    localparam int SW  = RW + CW;

    mcbb_pkg::t_state r_state, n_state;

    // control
    logic            r_out_valid;
    logic [CW-1:0]   r_vcount;
    logic            r_dv;
    logic            r_root;

    // sweep and search datapath
    logic [CW-1:0]   r_n;
    logic [XW-1:0]   r_i;
    logic [CW-1:0]   r_j;
    logic [XW-1:0]   r_dj;
    logic [RW-1:0]   r_acc;
    logic [XW-1:0]   r_cnt;
    logic [CW-1:0]   r_degi;
    logic [RW-1:0]   r_row;
    logic [CW-1:0]   r_d;
    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   r_new;
    logic [XW-1:0]   r_v;
    logic [RW-1:0]   r_cur;
    logic [RW-1:0]   r_best;
    logic [CW-1:0]   r_best_size;
    logic [mcbb_pkg::PRUNE_W-1:0] r_prune;
    logic [RW-1:0]   r_mask;

    // memories
    logic [RW-1:0]   m_adj  [MAX_VERTICES];
    logic [SW-1:0]   m_sym  [MAX_VERTICES];
    logic [XW-1:0]   m_rtv  [MAX_VERTICES];
    logic [RW-1:0]   m_radj [MAX_VERTICES];
    logic [RW-1:0]   m_cs   [MAX_VERTICES];

    logic [RW-1:0]   adj_rd;
    logic [SW-1:0]   sym_rd;
    logic [XW-1:0]   rtv_rd;
    logic [RW-1:0]   radj_rd;
    logic [RW-1:0]   cs_rd;

    logic            adj_we;
    logic [XW-1:0]   sym_ra, rtv_ra, radj_ra;
    logic            sym_we, rtv_we, radj_we, cs_we;

    logic            in_acc;
    logic            out_acc;
    logic [CW-1:0]   nclamp;
    logic [RW:0]     nm_w;
    logic [RW-1:0]   nmask;
    logic [CW-1:0]   nm1;
    logic            sweep;
    logic            issue;
    logic            last;
    logic            i_end;

    logic [RW-1:0]   acc_base;
    logic [RW-1:0]   above;
    logic [RW-1:0]   sym_acc_n;
    logic [RW-1:0]   ra_acc_n;
    logic [CW-1:0]   sdeg;
    logic            higher;
    logic [XW-1:0]   cnt_n;

    logic            rem_zero;
    logic            bound_fail;
    logic [RW-1:0]   vbit;
    logic [XW-1:0]   vidx;
    logic [RW-1:0]   rem_after;
    logic [RW-1:0]   new_cand;
    logic [RW-1:0]   rvbit;
    logic            deeper_best;

    logic            col_start;
    logic [RW-1:0]   col_cand;
    logic [CW-1:0]   col_base;
    mcbb_pkg::t_col_req  col_req;
    mcbb_pkg::t_col_stat col_stat;

    // handshakes
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_out_valid && i_out_ready;
    assign o_in_ready  = (r_state == mcbb_pkg::S_IDLE) && !(r_out_valid && i_kind);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_clique_size = r_best_size;
    assign o_clique_mask = r_mask;
    assign o_prune_count = r_prune;

    // vertex count and derived masks
    assign nclamp = (r_vcount > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : r_vcount;
    assign nm_w   = ((RW+1)'(1) << r_n) - (RW+1)'(1);
    assign nmask  = nm_w[RW-1:0];
    assign nm1    = r_n - 7'd1;

    // sweep pipeline: issue a read, process its data in the next cycle
    assign sweep = (r_state == mcbb_pkg::S_SYM) || (r_state == mcbb_pkg::S_RK_SWEEP) ||
                   (r_state == mcbb_pkg::S_RA_SWEEP) || (r_state == mcbb_pkg::S_MASK);
    assign issue = sweep && (r_j < r_n);
    assign last  = r_dv && ({1'b0, r_dj} == nm1);
    assign i_end = (r_i == nm1[XW-1:0]);

    // symmetric row: lower half from column of earlier rows, upper from own row
    assign acc_base = (r_dj == '0) ? '0 : r_acc;
    assign above    = ~((RW'(2) << r_i) - RW'(1));
    always_comb begin
        sym_acc_n = acc_base;
        if (r_dj < r_i) begin
            sym_acc_n[r_dj] = adj_rd[r_i];
        end else if (r_dj == r_i) begin
            sym_acc_n = acc_base | (adj_rd & above & nmask);
        end
    end

    // ranked adjacency bit
    always_comb begin
        ra_acc_n = acc_base;
        ra_acc_n[r_dj] = r_row[rtv_rd];
    end

    // rank: vertices of higher degree, or equal degree and lower index
    assign sdeg   = sym_rd[SW-1:RW];
    assign higher = (sdeg > r_degi) || ((sdeg == r_degi) && (r_dj < r_i));
    assign cnt_n  = ((r_dj == '0) ? '0 : r_cnt) + XW'(higher);

    // search step
    assign rem_zero    = (r_rem == '0);
    assign bound_fail  = ({1'b0, r_d} + {1'b0, mcbb_pkg::f_popcount(r_rem)}) <=
                         {1'b0, r_best_size};
    assign vbit        = mcbb_pkg::f_low_onehot(r_rem);
    assign vidx        = mcbb_pkg::f_encode(vbit);
    assign rem_after   = r_rem & ~vbit;
    assign new_cand    = r_rem & radj_rd;
    assign rvbit       = RW'(1) << r_v;
    assign deeper_best = ({1'b0, r_d} + 8'd1) > {1'b0, r_best_size};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcbb_pkg::S_IDLE: begin
                if (in_acc && i_kind) begin
                    n_state = (nclamp == '0) ? mcbb_pkg::S_OUT : mcbb_pkg::S_SYM;
                end
            end
            mcbb_pkg::S_SYM: begin
                if (last && i_end) begin
                    n_state = mcbb_pkg::S_RK_HEAD;
                end
            end
            mcbb_pkg::S_RK_HEAD: n_state = mcbb_pkg::S_RK_SWEEP;
            mcbb_pkg::S_RK_SWEEP: begin
                if (last) begin
                    n_state = i_end ? mcbb_pkg::S_RA_HEAD1 : mcbb_pkg::S_RK_HEAD;
                end
            end
            mcbb_pkg::S_RA_HEAD1: n_state = mcbb_pkg::S_RA_HEAD2;
            mcbb_pkg::S_RA_HEAD2: n_state = mcbb_pkg::S_RA_SWEEP;
            mcbb_pkg::S_RA_SWEEP: begin
                if (last) begin
                    n_state = i_end ? mcbb_pkg::S_ROOT : mcbb_pkg::S_RA_HEAD1;
                end
            end
            mcbb_pkg::S_ROOT: n_state = mcbb_pkg::S_COLOR;
            mcbb_pkg::S_LOOP: begin
                if (rem_zero) begin
                    n_state = (r_d == '0) ? mcbb_pkg::S_MASK : mcbb_pkg::S_POP;
                end else if (!bound_fail) begin
                    n_state = mcbb_pkg::S_BR_WAIT;
                end
            end
            mcbb_pkg::S_BR_WAIT: begin
                n_state = (new_cand == '0) ? mcbb_pkg::S_LOOP : mcbb_pkg::S_COLOR;
            end
            mcbb_pkg::S_COLOR: begin
                if (col_stat.done) begin
                    n_state = (col_stat.prune && r_root) ? mcbb_pkg::S_MASK
                                                         : mcbb_pkg::S_LOOP;
                end
            end
            mcbb_pkg::S_POP:      n_state = mcbb_pkg::S_POP_WAIT;
            mcbb_pkg::S_POP_WAIT: n_state = mcbb_pkg::S_LOOP;
            mcbb_pkg::S_MASK: begin
                if (last) begin
                    n_state = mcbb_pkg::S_OUT;
                end
            end
            mcbb_pkg::S_OUT: n_state = mcbb_pkg::S_IDLE;
            default:         n_state = mcbb_pkg::S_IDLE;
        endcase
    end

    // memory controls and coloring start
    always_comb begin
        adj_we    = in_acc && !i_kind && ({1'b0, i_row_index} < CW'(MAX_VERTICES));
        sym_we    = 1'b0;
        rtv_we    = 1'b0;
        radj_we   = 1'b0;
        cs_we     = 1'b0;
        sym_ra    = r_j[XW-1:0];
        rtv_ra    = r_j[XW-1:0];
        radj_ra   = vidx;
        col_start = 1'b0;
        col_cand  = new_cand;
        col_base  = r_d + 7'd1;
        case (r_state)
            mcbb_pkg::S_SYM:      sym_we = last;
            mcbb_pkg::S_RK_HEAD:  sym_ra = r_i;
            mcbb_pkg::S_RK_SWEEP: rtv_we = last;
            mcbb_pkg::S_RA_HEAD1: rtv_ra = r_i;
            mcbb_pkg::S_RA_HEAD2: sym_ra = rtv_rd;
            mcbb_pkg::S_RA_SWEEP: radj_we = last;
            mcbb_pkg::S_ROOT: begin
                col_start = 1'b1;
                col_cand  = nmask;
                col_base  = '0;
            end
            mcbb_pkg::S_LOOP:     cs_we = !rem_zero && !bound_fail;
            mcbb_pkg::S_BR_WAIT:  col_start = (new_cand != '0);
            mcbb_pkg::S_COLOR:    radj_ra = col_req.addr;
            default: ;
        endcase
    end

    // memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            m_adj[i_row_index[IW-1:0]] <= i_row_bits;
        end
        adj_rd <= m_adj[r_j[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            m_sym[r_i[IW-1:0]] <= {mcbb_pkg::f_popcount(sym_acc_n), sym_acc_n};
        end
        sym_rd <= m_sym[sym_ra[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (rtv_we) begin
            m_rtv[cnt_n[IW-1:0]] <= r_i;
        end
        rtv_rd <= m_rtv[rtv_ra[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (radj_we) begin
            m_radj[r_i[IW-1:0]] <= ra_acc_n;
        end
        radj_rd <= m_radj[radj_ra[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cs_we) begin
            m_cs[r_d[IW-1:0]] <= rem_after;
        end
        cs_rd <= m_cs[IW'(r_d - 7'd1)];
    end

    // coloring unit
    mcbb_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (col_start),
        .i_cand  (col_cand),
        .i_base  (col_base),
        .i_best  (r_best_size),
        .i_radj  (radj_rd),
        .o_req   (col_req),
        .o_stat  (col_stat)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcbb_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_vcount    <= '0;
            r_dv        <= 1'b0;
            r_root      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
            if (r_state == mcbb_pkg::S_OUT) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            r_dv <= issue && !last && (n_state == r_state);
            if (r_state == mcbb_pkg::S_ROOT) begin
                r_root <= 1'b1;
            end else if (r_state == mcbb_pkg::S_BR_WAIT) begin
                r_root <= 1'b0;
            end
        end
    end

    // sweep counters
    always_ff @(posedge i_clk) begin
        r_dj <= r_j[XW-1:0];
        if (last || (n_state != r_state)) begin
            r_j <= '0;
        end else if (issue) begin
            r_j <= r_j + 7'd1;
        end
        if (in_acc && i_kind) begin
            r_i <= '0;
        end else if (last && ((r_state == mcbb_pkg::S_SYM) ||
                              (r_state == mcbb_pkg::S_RK_SWEEP) ||
                              (r_state == mcbb_pkg::S_RA_SWEEP))) begin
            r_i <= i_end ? '0 : r_i + 6'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mcbb_pkg::S_IDLE: begin
                if (in_acc && i_kind) begin
                    r_n         <= nclamp;
                    r_best_size <= '0;
                    r_best      <= '0;
                    r_prune     <= '0;
                    r_cur       <= '0;
                    r_mask      <= '0;
                    r_d         <= '0;
                end
            end
            mcbb_pkg::S_SYM: begin
                if (r_dv) begin
                    r_acc <= sym_acc_n;
                end
            end
            mcbb_pkg::S_RK_SWEEP: begin
                if (!r_dv && (r_j == '0)) begin
                    r_degi <= sdeg;
                end
                if (r_dv) begin
                    r_cnt <= cnt_n;
                end
            end
            mcbb_pkg::S_RA_SWEEP: begin
                if (!r_dv && (r_j == '0)) begin
                    r_row <= sym_rd[RW-1:0];
                end
                if (r_dv) begin
                    r_acc <= ra_acc_n;
                end
            end
            mcbb_pkg::S_ROOT: begin
                r_rem <= nmask;
                r_new <= nmask;
                r_d   <= '0;
            end
            mcbb_pkg::S_LOOP: begin
                if (!rem_zero) begin
                    if (bound_fail) begin
                        if (r_prune != '1) begin
                            r_prune <= r_prune + 32'd1;
                        end
                        r_rem <= '0;
                    end else begin
                        r_rem <= rem_after;
                        r_cur <= r_cur | vbit;
                        r_v   <= vidx;
                    end
                end
            end
            mcbb_pkg::S_BR_WAIT: begin
                r_new <= new_cand;
                if (new_cand == '0) begin
                    if (deeper_best) begin
                        r_best_size <= r_d + 7'd1;
                        r_best      <= r_cur;
                    end
                    r_cur <= r_cur & ~rvbit;
                end
            end
            mcbb_pkg::S_COLOR: begin
                if (col_stat.done) begin
                    if (col_stat.prune) begin
                        if (r_prune != '1) begin
                            r_prune <= r_prune + 32'd1;
                        end
                        if (!r_root) begin
                            r_cur <= r_cur & ~rvbit;
                        end
                    end else if (!r_root) begin
                        r_d   <= r_d + 7'd1;
                        r_rem <= r_new;
                    end
                end
            end
            mcbb_pkg::S_POP: begin
                r_d   <= r_d - 7'd1;
                r_cur <= r_cur & ~mcbb_pkg::f_high_onehot(r_cur);
            end
            mcbb_pkg::S_POP_WAIT: r_rem <= cs_rd;
            mcbb_pkg::S_MASK: begin
                if (r_dv && r_best[r_dj]) begin
                    r_mask[rtv_rd] <= 1'b1;
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    // clique under construction has one member per open level
    a_depth_matches_clique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcbb_pkg::S_LOOP) |-> ($countones(r_cur) == int'(r_d)))
        else $error("clique size does not match search depth");

    // search depth never exceeds the vertex count
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcbb_pkg::S_LOOP) |-> (r_d <= r_n))
        else $error("search depth beyond vertex count");

    // a result appears only from the output step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == mcbb_pkg::S_OUT))
        else $error("result raised outside the output step");

    // the coloring unit is never started while the sequencer waits on it
    a_color_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcbb_pkg::S_COLOR) |-> !col_start)
        else $error("coloring restarted while busy");

    // best clique mask agrees with its size
    a_best_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcbb_pkg::S_MASK) |-> ($countones(r_best) == int'(r_best_size)))
        else $error("best clique mask does not match its size");
`endif

endmodule
`default_nettype wire

// ===== design/mcbb_color.sv =====
`default_nettype none
// Greedy coloring bound: builds color classes one after another in rank
// order and reports whether base plus class count cannot beat the best.
module mcbb_color (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [mcbb_pkg::ROW_W-1:0]         i_cand,
    input  wire logic [mcbb_pkg::CNT_W-1:0]         i_base,
    input  wire logic [mcbb_pkg::CNT_W-1:0]         i_best,
    input  wire logic [mcbb_pkg::ROW_W-1:0]         i_radj,
    output mcbb_pkg::t_col_req                      o_req,
    output mcbb_pkg::t_col_stat                     o_stat
);

    mcbb_pkg::t_col_state r_state, n_state;

    logic [mcbb_pkg::ROW_W-1:0] r_rem;
    logic [mcbb_pkg::ROW_W-1:0] r_avail;
    logic [mcbb_pkg::CNT_W-1:0] r_used;

    logic                       avail_zero;
    logic                       rem_zero;
    logic [mcbb_pkg::CNT_W-1:0] used_inc;
    logic                       over;
    logic [mcbb_pkg::ROW_W-1:0] pick_bit;

    assign avail_zero = (r_avail == '0);
    assign rem_zero   = (r_rem == '0);
    assign used_inc   = r_used + 7'd1;
    assign over       = ({1'b0, i_base} + {1'b0, used_inc}) > {1'b0, i_best};
    assign pick_bit   = mcbb_pkg::f_low_onehot(r_avail);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcbb_pkg::C_IDLE: begin
                if (i_start) begin
                    n_state = mcbb_pkg::C_PICK;
                end
            end
            mcbb_pkg::C_PICK: begin
                if (avail_zero) begin
                    if (rem_zero || over) begin
                        n_state = mcbb_pkg::C_IDLE;
                    end
                end else begin
                    n_state = mcbb_pkg::C_WAIT;
                end
            end
            mcbb_pkg::C_WAIT: n_state = mcbb_pkg::C_PICK;
            default:          n_state = mcbb_pkg::C_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req.addr   = mcbb_pkg::f_encode(pick_bit);
        o_stat.done  = 1'b0;
        o_stat.prune = rem_zero;
        case (r_state)
            mcbb_pkg::C_PICK: o_stat.done = avail_zero && (rem_zero || over);
            default:          o_stat.done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcbb_pkg::C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // class building: open a class on all remaining, drop neighbors of each pick
    always_ff @(posedge i_clk) begin
        case (r_state)
            mcbb_pkg::C_IDLE: begin
                if (i_start) begin
                    r_rem   <= i_cand;
                    r_avail <= '0;
                    r_used  <= '0;
                end
            end
            mcbb_pkg::C_PICK: begin
                if (avail_zero) begin
                    if (!rem_zero) begin
                        r_used  <= used_inc;
                        r_avail <= r_rem;
                    end
                end else begin
                    r_rem   <= r_rem & ~pick_bit;
                    r_avail <= r_avail & ~pick_bit;
                end
            end
            mcbb_pkg::C_WAIT: r_avail <= r_avail & ~i_radj;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== verif/mcbb_checker.sv =====
`default_nettype none
module mcbb_checker
    import mcbb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic               i_kind,
    input  wire logic [IDX_W-1:0]   i_row_index,
    input  wire logic [ROW_W-1:0]   i_row_bits,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [CNT_W-1:0]   i_clique_size,
    input  wire logic [ROW_W-1:0]   i_clique_mask,
    input  wire logic [PRUNE_W-1:0] i_prune_count,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [CNT_W-1:0]   i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_solves_seen
);

    typedef struct packed {
        logic [CNT_W-1:0]   size;
        logic [ROW_W-1:0]   mask;
        logic [PRUNE_W-1:0] prunes;
    } t_clique_result;

    // local copy of the graph and configuration
    logic [ROW_W-1:0] graph_rows [64];
    logic [ROW_W-1:0] ranked_adj [64];
    logic [IDX_W-1:0] rank_vertex [64];
    logic [CNT_W-1:0] vertex_cnt;

    // search scratch
    logic [ROW_W-1:0]   best_set;
    int                 best_cnt;
    logic [PRUNE_W-1:0] prune_tally;

    t_clique_result expected_cliques [$];
    int             mismatches;
    int             solves_seen;

    initial begin
        mismatches = 0;
        solves_seen = 0;
        vertex_cnt = '0;
    end

    task automatic note_mismatch(input string what, input logic [ROW_W-1:0] got,
                                 input logic [ROW_W-1:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic void bump_prunes();
        if (prune_tally != '1) begin
            prune_tally = prune_tally + 1'b1;
        end
    endfunction

    // greedy color classes over candidates in rank order
    function automatic int color_classes(input logic [ROW_W-1:0] cand);
        logic [ROW_W-1:0] cls [64];
        int used;
        int r;
        int c;
        used = 0;
        while (cand != '0) begin
            r = 0;
            while (!cand[r]) r++;
            cand[r] = 1'b0;
            c = 0;
            while (c < used && (cls[c] & ranked_adj[r]) != '0) c++;
            if (c == used) begin
                cls[c] = '0;
                used++;
            end
            cls[c][r] = 1'b1;
        end
        return used;
    endfunction

    // returns 1 when the frame is to be branched on
    function automatic bit enter_frame(input int d, input logic [ROW_W-1:0] cand,
                                       input logic [ROW_W-1:0] cur);
        if (cand == '0) begin
            if (d > best_cnt) begin
                best_cnt = d;
                best_set = cur;
            end
            return 1'b0;
        end
        if (d + color_classes(cand) <= best_cnt) begin
            bump_prunes();
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_clique_result find_clique(input int n);
        logic [ROW_W-1:0] sym [64];
        int deg [64];
        logic [ROW_W-1:0] cand_stk [65];
        logic [ROW_W-1:0] cur;
        logic [ROW_W-1:0] rem;
        logic [ROW_W-1:0] vbit;
        int d;
        int r;
        int v;
        t_clique_result res;
        best_set = '0;
        best_cnt = 0;
        prune_tally = '0;
        cur = '0;
        res = '0;
        if (n == 0) begin
            return res;
        end
        // symmetric adjacency from the upper triangle
        for (int i = 0; i < n; i++) begin
            sym[i] = '0;
            for (int j = 0; j < n; j++) begin
                if (i != j) begin
                    sym[i][j] = (i < j) ? graph_rows[i][j] : graph_rows[j][i];
                end
            end
            deg[i] = $countones(sym[i]);
        end
        // rank by degree, ties to lower index
        for (int i = 0; i < n; i++) begin
            r = 0;
            for (int j = 0; j < n; j++) begin
                if (deg[j] > deg[i] || (deg[j] == deg[i] && j < i)) r++;
            end
            rank_vertex[r] = IDX_W'(i);
        end
        for (int i = 0; i < n; i++) begin
            ranked_adj[i] = '0;
            for (int j = 0; j < n; j++) begin
                ranked_adj[i][j] = sym[rank_vertex[i]][rank_vertex[j]];
            end
        end
        cand_stk[0] = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        if (enter_frame(0, cand_stk[0], cur)) begin
            d = 0;
            while (1) begin
                rem = cand_stk[d];
                if (rem == '0) begin
                    if (d == 0) break;
                    d--;
                    for (int k = 63; k >= 0; k--) begin
                        if (cur[k]) begin
                            cur[k] = 1'b0;
                            break;
                        end
                    end
                    continue;
                end
                if (d + $countones(rem) <= best_cnt) begin
                    bump_prunes();
                    cand_stk[d] = '0;
                    continue;
                end
                vbit = rem & (~rem + 64'd1);
                v = 0;
                while (!vbit[v]) v++;
                cand_stk[d] = rem & ~vbit;
                cur = cur | vbit;
                cand_stk[d+1] = cand_stk[d] & ranked_adj[v];
                if (enter_frame(d + 1, cand_stk[d+1], cur)) begin
                    d++;
                end else begin
                    cur = cur & ~vbit;
                end
            end
        end
        // map ranks back to vertex numbers
        for (int i = 0; i < n; i++) begin
            if (best_set[i]) res.mask[rank_vertex[i]] = 1'b1;
        end
        res.size = CNT_W'(best_cnt);
        res.prunes = prune_tally;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_clique_result want;
        int n;
        if (!i_rst_n) begin
            vertex_cnt = '0;
            expected_cliques.delete();
        end else begin
            // result side
            if (i_out_valid && i_out_ready) begin
                if (expected_cliques.size() == 0) begin
                    note_mismatch("unexpected result", i_clique_mask, '0);
                end else begin
                    want = expected_cliques.pop_front();
                    solves_seen++;
                    if (i_clique_size !== want.size)
                        note_mismatch("clique_size", ROW_W'(i_clique_size), ROW_W'(want.size));
                    if (i_clique_mask !== want.mask)
                        note_mismatch("clique_mask", i_clique_mask, want.mask);
                    if (i_prune_count !== want.prunes)
                        note_mismatch("prune_count", ROW_W'(i_prune_count),
                                      ROW_W'(want.prunes));
                end
            end
            // configuration write
            if (i_cfg_valid && i_cfg_ready) begin
                vertex_cnt = i_cfg_data;
            end
            // request side
            if (i_in_valid && i_in_ready) begin
                if (!i_kind) begin
                    graph_rows[i_row_index] = i_row_bits;
                end else begin
                    n = (vertex_cnt > 7'd64) ? 64 : int'(vertex_cnt);
                    expected_cliques.push_back(find_clique(n));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending <= expected_cliques.size();
        o_solves_seen <= solves_seen;
    end

endmodule
`default_nettype wire

// ===== verif/tb_max_clique_branch_bound.sv =====
`default_nettype none
module tb_max_clique_branch_bound;
    import mcbb_pkg::*;

    localparam int LIMIT_CYCLES = 40_000_000;
    localparam int ITEM_GOAL    = 1750;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               kind = 1'b0;
    logic [IDX_W-1:0]   row_index = '0;
    logic [ROW_W-1:0]   row_bits = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CNT_W-1:0]   clique_size;
    logic [ROW_W-1:0]   clique_mask;
    logic [PRUNE_W-1:0] prune_count;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   cfg_data = '0;

    int  fail_count;
    int  pending;
    int  solves_seen;
    int  item_cnt = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    int  row_mode = 0;
    logic [63:0] rows_loaded = '0;
    logic [CNT_W-1:0] cur_count = '0;

    max_clique_branch_bound u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_kind       (kind),
        .i_row_index  (row_index),
        .i_row_bits   (row_bits),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_clique_size(clique_size),
        .o_clique_mask(clique_mask),
        .o_prune_count(prune_count),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    mcbb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_kind       (kind),
        .i_row_index  (row_index),
        .i_row_bits   (row_bits),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_clique_size(clique_size),
        .i_clique_mask(clique_mask),
        .i_prune_count(prune_count),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_solves_seen(solves_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20.0 * LIMIT_CYCLES);
        $display("max_clique_branch_bound verification failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on demand
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                while (!out_valid) @(posedge i_clk);
                for (int c = 0; c < 400; c++) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // one request, with random gaps before it
    task automatic send_item(input logic k, input logic [IDX_W-1:0] idx,
                             input logic [ROW_W-1:0] bits);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        row_index <= idx;
        row_bits  <= bits;
        do @(posedge i_clk); while (!in_ready);
        item_cnt++;
    endtask

    task automatic load_row(input int idx, input logic [ROW_W-1:0] bits);
        send_item(1'b0, IDX_W'(idx), bits);
        rows_loaded[idx] = 1'b1;
    endtask

    function automatic logic [ROW_W-1:0] make_row();
        case (row_mode)
            0: return {$urandom, $urandom};
            1: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            2: return {$urandom, $urandom} | {$urandom, $urandom};
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    // solve request; rows in use are loaded first
    task automatic solve_now();
        int n;
        n = (cur_count > 7'd64) ? 64 : int'(cur_count);
        for (int r = 0; r < n; r++) begin
            if (!rows_loaded[r]) load_row(r, make_row());
        end
        send_item(1'b1, IDX_W'($urandom_range(63)), {$urandom, $urandom});
    endtask

    // drain results, let the block settle, then write the register
    task automatic set_count(input logic [CNT_W-1:0] n);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_count = n;
    endtask

    initial begin
        int phase;
        int items;
        int big_pick;
        logic [CNT_W-1:0] n;
        phase = 0;
        big_pick = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty graph, single vertex, edge symmetry, clique with junk bits
        set_count(7'd0);
        solve_now();
        set_count(7'd1);
        load_row(0, '1);
        solve_now();
        set_count(7'd2);
        load_row(0, 64'h2);
        load_row(1, 64'h0);
        solve_now();
        load_row(0, 64'h0);
        load_row(1, 64'h1);
        solve_now();
        set_count(7'd5);
        for (int r = 1; r < 5; r++) load_row(r, '1);
        solve_now();

        // random phases
        while (item_cnt < ITEM_GOAL) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (phase % 9 == 4) begin
                // full-size graph, kept sparse so the search stays short
                case (big_pick % 3)
                    0: n = 7'd64;
                    1: n = 7'd65;
                    default: n = 7'd127;
                endcase
                big_pick++;
                set_count(n);
                row_mode = 1;
                for (int r = 0; r < 64; r++) load_row(r, make_row());
                solve_now();
                for (int k = 0; k < 6; k++) load_row($urandom_range(63), make_row());
                solve_now();
            end else begin
                n = ($urandom_range(9) < 7) ? CNT_W'($urandom_range(10, 2))
                                            : CNT_W'($urandom_range(20, 11));
                set_count(n);
                row_mode = $urandom_range(3);
                if (phase == 2) begin
                    // held result blocks the second solve request
                    hold_request = 1'b1;
                    solve_now();
                    solve_now();
                end
                items = 20 + $urandom_range(15);
                for (int k = 0; k < items; k++) begin
                    if ($urandom_range(7) == 0) solve_now();
                    else load_row($urandom_range(63), make_row());
                end
                solve_now();
            end
            phase++;
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Covered %0d requests over %0d phases, %0d solve results checked.",
                 item_cnt, phase, solves_seen);
        $display("Sizes from empty to full 64 vertices, under all idle and stall mixes.");
        if (fail_count == 0) begin
            $display("max_clique_branch_bound verification clean");
        end else begin
            $display("max_clique_branch_bound verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
